@@ sv/bsrp_pkg.sv @@
// shared types and constants for the beam stack block
package bsrp_pkg;

  // command codes
  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  // result status codes
  localparam logic [2:0] StDiscard = 3'd0;
  localparam logic [2:0] StInsert  = 3'd1;
  localparam logic [2:0] StReplace = 3'd2;
  localparam logic [2:0] StLost    = 3'd3;
  localparam logic [2:0] StPruned  = 3'd4;
  localparam logic [2:0] StCleared = 3'd5;
  localparam logic [2:0] StBest    = 3'd6;
  localparam logic [2:0] StEmpty   = 3'd7;

  // configuration register indexes
  localparam logic RegBeam = 1'b0;
  localparam logic RegSize = 1'b1;

  localparam logic signed [31:0] ScoreMin = 32'sh8000_0000;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StDecide,
    StCand,
    StOuter,
    StInner,
    StOuterEnd,
    StPrune,
    StQuery
  } state_e;

endpackage

@@ sv/beam_stack_recombine_prune.sv @@
// beam search stack with recombination and histogram pruning
// an add scans all slots for its key and a free slot, then decides; a query scans all
//   slots for the best score; clear and early discard answer next cycle
// an add that prunes stays busy further for the count, selection and removal sweeps
//   (one read port, one entry a cycle)
// throughput: one command at a time; busy is high until its last result
// reset: valid bits, count and bounds clear at once; no memory clearing pass
module beam_stack_recombine_prune #(
  parameter int MAX_KEEP = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  logic [1:0]               command_i,
  input  logic [31:0]              recomb_key_i,
  input  logic signed [31:0]       item_score_i,
  input  logic [15:0]              item_id_i,
  output logic                     strobe,
  output logic [2:0]               status_o,
  output logic [15:0]              other_id_o,
  output logic signed [31:0]       other_score_o,
  output logic [5:0]               entry_count_o,
  output logic                     last_o
);

  localparam int Slots = 2 * MAX_KEEP;
  localparam int AW = $clog2(Slots);
  localparam int CW = $clog2(Slots + 1);

  // slot memory: key, score, id
  logic [KEY_BITS-1:0]  mem_key [Slots];
  logic signed [31:0]   mem_score [Slots];
  logic [15:0]          mem_id [Slots];
  logic [Slots-1:0]     valid_q, valid_d;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_BITS-1:0]  rd_key;
  logic signed [31:0]   rd_score;
  logic [15:0]          rd_id;

  bsrp_pkg::state_e     state_q, state_d;
  logic signed [31:0]   beam_q, beam_d, best_q, best_d, worst_q, worst_d;
  logic [4:0]           size_q, size_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW:0]          i_q, i_d, j_q, j_d;
  logic [AW-1:0]        rslot_q, rslot_d;  // slot of the data now on the read port
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic signed [31:0]   sc_q, sc_d;
  logic [15:0]          id_q, id_d;
  logic                 hit_q, hit_d, fr_q, fr_d, any_q, any_d, found_q, found_d;
  logic                 usebnd_q, usebnd_d, rv_q, rv_d;
  logic [AW-1:0]        at_q, at_d, fs_q, fs_d;
  logic signed [31:0]   osc_q, osc_d, thr_q, thr_d, cur_q, cur_d, bnd_q, bnd_d;
  logic [15:0]          oid_q, oid_d;
  logic [CW-1:0]        cand_q, cand_d, ge_q, ge_d;
  logic [CW-1:0]        k_eff;
  logic                 st_q, st_d, ls_q, ls_d;
  logic [2:0]           sts_q, sts_d;
  logic [15:0]          oi_q, oi_d;
  logic signed [31:0]   os_q, os_d;
  logic [5:0]           ec_q, ec_d;

  // slot memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_key[waddr]   <= key_q;
      mem_score[waddr] <= sc_q;
      mem_id[waddr]    <= id_q;
    end
    rd_key   <= mem_key[raddr];
    rd_score <= mem_score[raddr];
    rd_id    <= mem_id[raddr];
  end

  // effective stack size and saturated bound sum over the updated best bound
  logic [4:0]           size_eff;
  logic signed [31:0]   best_n;
  logic signed [32:0]   bsum_w;
  logic signed [31:0]   bsum, beam_c;
  logic                 cur_use;
  assign size_eff = (size_q == 5'd0) ? 5'd1 :
                    ({27'd0, size_q} > MAX_KEEP) ? 5'(MAX_KEEP) : size_q;
  assign beam_c = beam_q[31] ? beam_q : 32'sd0;
  assign best_n = (sc_q > best_q) ? sc_q : best_q;
  assign bsum_w = {best_n[31], best_n} + {beam_c[31], beam_c};
  assign bsum = (bsum_w[32] != bsum_w[31]) ?
                (bsum_w[32] ? bsrp_pkg::ScoreMin : 32'sh7fff_ffff) : bsum_w[31:0];
  assign k_eff = (CW'(size_eff) > cand_q) ? cand_q : CW'(size_eff);
  assign cur_use = valid_q[rslot_q] && (!usebnd_q || rd_score > bnd_q);

  assign busy = (state_q != bsrp_pkg::StIdle);
  assign strobe = st_q;
  assign status_o = sts_q;
  assign other_id_o = oi_q;
  assign other_score_o = os_q;
  assign entry_count_o = ec_q;
  assign last_o = ls_q;

  // next state and datapath
  always_comb begin
    state_d = state_q; beam_d = beam_q; size_d = size_q; best_d = best_q;
    worst_d = worst_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; rslot_d = rslot_q;
    key_d = key_q; sc_d = sc_q; id_d = id_q; hit_d = hit_q;
    fr_d = fr_q; any_d = any_q; found_d = found_q; usebnd_d = usebnd_q;
    at_d = at_q; fs_d = fs_q; osc_d = osc_q; thr_d = thr_q; cur_d = cur_q;
    bnd_d = bnd_q; oid_d = oid_q; cand_d = cand_q; ge_d = ge_q; rv_d = 1'b0;
    valid_d = valid_q; st_d = 1'b0; ls_d = 1'b0; sts_d = sts_q; oi_d = oi_q;
    os_d = os_q; ec_d = ec_q; we = 1'b0; waddr = at_q; raddr = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == bsrp_pkg::RegBeam) beam_d = cfg_data_i;
      else size_d = cfg_data_i[4:0];
    end

    unique case (state_q)
      bsrp_pkg::StIdle: begin
        if (start) begin
          key_d = recomb_key_i[KEY_BITS-1:0];
          sc_d = item_score_i; id_d = item_id_i;
          hit_d = 1'b0; fr_d = 1'b0; any_d = 1'b0; i_d = '0;
          unique case (command_i)
            bsrp_pkg::CmdAdd: begin
              if (item_score_i < worst_q) begin
                st_d = 1'b1; ls_d = 1'b1; sts_d = bsrp_pkg::StDiscard;
                oi_d = '0; os_d = '0; ec_d = 6'(cnt_q);
              end else state_d = bsrp_pkg::StScan;
            end
            bsrp_pkg::CmdClear: begin
              valid_d = '0; cnt_d = '0; st_d = 1'b1; ls_d = 1'b1;
              sts_d = bsrp_pkg::StCleared; oi_d = '0; os_d = '0; ec_d = '0;
            end
            bsrp_pkg::CmdQuery: state_d = bsrp_pkg::StQuery;
            default: ;
          endcase
        end
      end
      // key search and first free slot, or best score for a query, one slot a cycle
      bsrp_pkg::StScan, bsrp_pkg::StQuery: begin
        if (rv_q) begin
          if (state_q == bsrp_pkg::StScan) begin
            if (valid_q[rslot_q] && rd_key == key_q && !hit_q) begin
              hit_d = 1'b1; at_d = rslot_q; osc_d = rd_score; oid_d = rd_id;
            end
            if (!valid_q[rslot_q] && !fr_q) begin
              fr_d = 1'b1; fs_d = rslot_q;
            end
          end else if (valid_q[rslot_q] && (!any_q || rd_score > osc_q)) begin
            any_d = 1'b1; osc_d = rd_score; oid_d = rd_id;
          end
        end
        if (i_q < (AW+1)'(Slots)) begin
          raddr = i_q[AW-1:0]; rslot_d = i_q[AW-1:0]; rv_d = 1'b1;
          i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          if (state_q == bsrp_pkg::StQuery) begin
            state_d = bsrp_pkg::StIdle; st_d = 1'b1; ls_d = 1'b1;
            ec_d = 6'(cnt_q);
            sts_d = any_q ? bsrp_pkg::StBest : bsrp_pkg::StEmpty;
            oi_d = any_q ? oid_q : '0; os_d = any_q ? osc_q : '0;
          end else state_d = bsrp_pkg::StDecide;
        end
      end
      bsrp_pkg::StDecide: begin
        state_d = bsrp_pkg::StIdle; st_d = 1'b1; ls_d = 1'b1;
        if (hit_q && sc_q <= osc_q) begin
          sts_d = bsrp_pkg::StLost; oi_d = oid_q; os_d = osc_q; ec_d = 6'(cnt_q);
        end else if (!hit_q && !fr_q) begin
          sts_d = bsrp_pkg::StDiscard; oi_d = '0; os_d = '0; ec_d = 6'(cnt_q);
        end else begin
          waddr = hit_q ? at_q : fs_q; we = 1'b1;
          valid_d[waddr] = 1'b1;
          if (!hit_q) cnt_d = cnt_q + 1'b1;
          if (sc_q > best_q) begin
            best_d = sc_q;
            if (bsum > worst_q) worst_d = bsum;
          end
          sts_d = hit_q ? bsrp_pkg::StReplace : bsrp_pkg::StInsert;
          oi_d = hit_q ? oid_q : '0; os_d = hit_q ? osc_q : '0;
          ec_d = 6'(cnt_d);
          if ({1'b0, cnt_d} >= (CW+1)'({size_eff, 1'b0})) begin
            ls_d = 1'b0; state_d = bsrp_pkg::StCand; i_d = '0;
            cand_d = '0; usebnd_d = 1'b1; bnd_d = bsum; found_d = 1'b0;
          end
        end
      end
      // count candidates above the bound, fall back to all held
      bsrp_pkg::StCand: begin
        if (rv_q && cur_use) cand_d = cand_q + 1'b1;
        if (i_q < (AW+1)'(Slots)) begin
          raddr = i_q[AW-1:0]; rslot_d = i_q[AW-1:0]; rv_d = 1'b1;
          i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          if (cand_q == '0 && usebnd_q) begin
            usebnd_d = 1'b0; i_d = '0;
          end else begin
            i_d = '0; state_d = bsrp_pkg::StOuter;
          end
        end
      end
      // threshold selection: outer slot fetch
      bsrp_pkg::StOuter: begin
        if (rv_q) begin
          if (cur_use) begin
            cur_d = rd_score; ge_d = '0; j_d = '0; state_d = bsrp_pkg::StInner;
          end else begin
            // skipped entries leave ge at zero, which never wins with k >= 1
            ge_d = '0; state_d = bsrp_pkg::StOuterEnd;
          end
        end else if (i_q < (AW+1)'(Slots)) begin
          raddr = i_q[AW-1:0]; rslot_d = i_q[AW-1:0]; rv_d = 1'b1;
        end else begin
          state_d = found_q ? bsrp_pkg::StPrune : bsrp_pkg::StIdle;
          i_d = '0;
        end
      end
      bsrp_pkg::StInner: begin
        if (rv_q && cur_use && rd_score >= cur_q) ge_d = ge_q + 1'b1;
        if (j_q < (AW+1)'(Slots)) begin
          raddr = j_q[AW-1:0]; rslot_d = j_q[AW-1:0]; rv_d = 1'b1;
          j_d = j_q + 1'b1;
        end else if (!rv_q) state_d = bsrp_pkg::StOuterEnd;
      end
      bsrp_pkg::StOuterEnd: begin
        if (ge_q >= k_eff && (!found_q || cur_q > thr_q)) begin
          thr_d = cur_q; found_d = 1'b1;
        end
        ge_d = '0; i_d = i_q + 1'b1; state_d = bsrp_pkg::StOuter;
      end
      // remove entries below threshold in slot order
      bsrp_pkg::StPrune: begin
        if (rv_q && valid_q[rslot_q] && rd_score < thr_q) begin
          valid_d[rslot_q] = 1'b0; cnt_d = cnt_q - 1'b1;
          st_d = 1'b1; sts_d = bsrp_pkg::StPruned; oi_d = rd_id; os_d = rd_score;
          ec_d = 6'(cnt_d);
        end
        if (i_q < (AW+1)'(Slots)) begin
          raddr = i_q[AW-1:0]; rslot_d = i_q[AW-1:0]; rv_d = 1'b1;
          i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          // final strobe may be the last removal; the held result leaves with last set
          worst_d = thr_q; state_d = bsrp_pkg::StIdle;
        end
      end
      default: state_d = bsrp_pkg::StIdle;
    endcase
  end

  // result register with one-deep hold so the last flag lands on the final one
  logic       hv_q;
  logic [2:0] hs_q;
  logic [15:0] hi_q;
  logic signed [31:0] hc_q;
  logic [5:0] he_q;
  logic       fin;
  assign fin = (state_q != bsrp_pkg::StIdle) && (state_d == bsrp_pkg::StIdle) &&
               (state_q == bsrp_pkg::StPrune || state_q == bsrp_pkg::StOuter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsrp_pkg::StIdle; beam_q <= -32'sd655360; size_q <= 5'd16;
      best_q <= bsrp_pkg::ScoreMin; worst_q <= bsrp_pkg::ScoreMin; cnt_q <= '0;
      valid_q <= '0; st_q <= 1'b0; rv_q <= 1'b0; hv_q <= 1'b0; i_q <= '0;
    end else begin
      state_q <= state_d; beam_q <= beam_d; size_q <= size_d; best_q <= best_d;
      worst_q <= worst_d; cnt_q <= cnt_d; valid_q <= valid_d; rv_q <= rv_d;
      i_q <= i_d;
      // results of a prune chain are held back by one result so last can be set
      if (st_d && ls_d) begin
        st_q <= 1'b1;
        hv_q <= 1'b0;
      end else if (st_d) begin
        st_q <= hv_q;
        hv_q <= 1'b1;
      end else if (fin) begin
        st_q <= hv_q;
        hv_q <= 1'b0;
      end else st_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; rslot_q <= rslot_d; key_q <= key_d; sc_q <= sc_d;
    id_q <= id_d; hit_q <= hit_d; fr_q <= fr_d; any_q <= any_d;
    found_q <= found_d; usebnd_q <= usebnd_d; at_q <= at_d; fs_q <= fs_d;
    osc_q <= osc_d; thr_q <= thr_d; cur_q <= cur_d; bnd_q <= bnd_d;
    oid_q <= oid_d; cand_q <= cand_d; ge_q <= ge_d;
    if (st_d && ls_d) begin
      sts_q <= sts_d; oi_q <= oi_d; os_q <= os_d; ec_q <= ec_d; ls_q <= 1'b1;
    end else if (st_d) begin
      sts_q <= hs_q; oi_q <= hi_q; os_q <= hc_q; ec_q <= he_q; ls_q <= 1'b0;
      hs_q <= sts_d; hi_q <= oi_d; hc_q <= os_d; he_q <= ec_d;
    end else if (fin) begin
      sts_q <= hs_q; oi_q <= hi_q; os_q <= hc_q; ec_q <= he_q; ls_q <= 1'b1;
    end
  end

endmodule
